// ----- design/wpf_pkg.sv -----
// Shared types, constants and helpers of the weighted parabola fit core.
// Used by wpf_mul, wpf_div and weighted_parabola_fit_core; depends on nothing.
package wpf_pkg;

    localparam int DATA_W         = 32;
    localparam int SUM_W          = 64;
    localparam int OPND_W         = 128;
    localparam int PROD_W         = OPND_W + SUM_W;
    localparam int ACC_W          = 196;
    localparam int OUT_FRAC       = 24;
    localparam int NUM_W          = ACC_W + OUT_FRAC;
    localparam int COEF_W         = 48;
    localparam int MIN_POINTS     = 4;
    localparam int MAX_POINTS_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int IN_TDATA_W     = 96;
    localparam int OUT_TDATA_W    = 152;
    localparam int STEP_W         = 5;

    localparam logic [2:0] REG_USE_WEIGHTS = 3'd0;

    typedef enum logic [1:0] {
        FIT_OK       = 2'd0,
        FIT_FEW      = 2'd1,
        FIT_SINGULAR = 2'd2
    } fit_status_t;

    // Operands of the solve: power sums, moment sums and cofactors.
    typedef enum logic [3:0] {
        OP_S0, OP_S1, OP_S2, OP_S3, OP_S4,
        OP_M0, OP_M1, OP_M2,
        OP_C00, OP_C01, OP_C02, OP_C11, OP_C12, OP_C22
    } opnd_t;

    typedef enum logic [3:0] {
        D_NONE, D_C00, D_C01, D_C02, D_C11, D_C12, D_C22, D_DET, D_NUM
    } dest_t;

    typedef struct packed {
        opnd_t xsel;
        opnd_t ysel;
        logic  clear;
        logic  sub;
        dest_t dest;
    } solve_op_t;

    typedef struct packed {
        logic start;
        logic x_wide;
        logic y_wide;
        logic clear;
        logic sub;
    } mul_req_t;

    function automatic logic signed [SUM_W-1:0] sat_add64(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1])
        begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

    // Micro-program of the solve: six cofactors, the determinant and the
    // three numerators, each a short chain of multiply-accumulate steps.
    function automatic solve_op_t solve_op(input logic [STEP_W-1:0] step);
        solve_op_t o;
        case (step)
            5'd0:    o = '{OP_S2,  OP_S4, 1'b1, 1'b0, D_NONE};
            5'd1:    o = '{OP_S3,  OP_S3, 1'b0, 1'b1, D_C00};
            5'd2:    o = '{OP_S3,  OP_S2, 1'b1, 1'b0, D_NONE};
            5'd3:    o = '{OP_S1,  OP_S4, 1'b0, 1'b1, D_C01};
            5'd4:    o = '{OP_S1,  OP_S3, 1'b1, 1'b0, D_NONE};
            5'd5:    o = '{OP_S2,  OP_S2, 1'b0, 1'b1, D_C02};
            5'd6:    o = '{OP_S0,  OP_S4, 1'b1, 1'b0, D_NONE};
            5'd7:    o = '{OP_S2,  OP_S2, 1'b0, 1'b1, D_C11};
            5'd8:    o = '{OP_S2,  OP_S1, 1'b1, 1'b0, D_NONE};
            5'd9:    o = '{OP_S3,  OP_S0, 1'b0, 1'b1, D_C12};
            5'd10:   o = '{OP_S0,  OP_S2, 1'b1, 1'b0, D_NONE};
            5'd11:   o = '{OP_S1,  OP_S1, 1'b0, 1'b1, D_C22};
            5'd12:   o = '{OP_C00, OP_S0, 1'b1, 1'b0, D_NONE};
            5'd13:   o = '{OP_C01, OP_S1, 1'b0, 1'b0, D_NONE};
            5'd14:   o = '{OP_C02, OP_S2, 1'b0, 1'b0, D_DET};
            5'd15:   o = '{OP_C00, OP_M0, 1'b1, 1'b0, D_NONE};
            5'd16:   o = '{OP_C01, OP_M1, 1'b0, 1'b0, D_NONE};
            5'd17:   o = '{OP_C02, OP_M2, 1'b0, 1'b0, D_NUM};
            5'd18:   o = '{OP_C01, OP_M0, 1'b1, 1'b0, D_NONE};
            5'd19:   o = '{OP_C11, OP_M1, 1'b0, 1'b0, D_NONE};
            5'd20:   o = '{OP_C12, OP_M2, 1'b0, 1'b0, D_NUM};
            5'd21:   o = '{OP_C02, OP_M0, 1'b1, 1'b0, D_NONE};
            5'd22:   o = '{OP_C12, OP_M1, 1'b0, 1'b0, D_NONE};
            5'd23:   o = '{OP_C22, OP_M2, 1'b0, 1'b0, D_NUM};
            default: o = '{OP_S0,  OP_S0, 1'b1, 1'b0, D_NONE};
        endcase
        return o;
    endfunction

endpackage

// ----- design/weighted_parabola_fit_core.sv -----
// Top level of the weighted parabola fit core: sequencer, sums and ports.
// Depends on wpf_pkg, wpf_mul and wpf_div.
//
// Points stream in one item at a time; up to MAX_POINTS go into five weighted
// power sums and three value moments using one shared 32 x 32 bit multiplier
// (seven multiplies of two partial products each, plus the sum updates).
// A point flagged last then starts the solve, if at least four points were
// taken: 24 multiply-accumulate steps of up to eight partial products each
// for the cofactors, determinant and numerators, and three bit-serial
// divisions, before the result item with coef_const, coef_linear,
// coef_square and fit_status appears. No input item is taken while a point or
// a solve is in progress; a finished result waits in the output register
// while the next set is accumulated. use_weights is written over APB at
// address 0.
module weighted_parabola_fit_core #(
    parameter int MAX_POINTS = wpf_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = wpf_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample_value [31:0], abscissa [63:32], weight [95:64]
    input  logic [wpf_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // coef_const [47:0], coef_linear [95:48], coef_square [143:96],
    // fit_status [145:144], zero [151:146]
    output logic [wpf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import wpf_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] ONE  = SUM_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_PSUM, S_MWAIT, S_TWAIT, S_CHECK,
        S_SOLX, S_SOLY, S_SWAIT, S_DWAIT, S_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic                     use_w_reg, use_w_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [SUM_W-1:0]  psum_reg [5];
    logic signed [SUM_W-1:0]  psum_next [5];
    logic signed [SUM_W-1:0]  msum_reg [3];
    logic signed [SUM_W-1:0]  msum_next [3];
    logic signed [OPND_W-1:0] cof_reg [6];
    logic signed [OPND_W-1:0] cof_next [6];
    logic signed [ACC_W-1:0]  det_reg, det_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] absc_reg, absc_next;
    logic                     last_reg, last_next;
    logic signed [SUM_W-1:0]  term_reg, term_next;
    logic [2:0]               k_reg, k_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [OPND_W-1:0] opx_reg, opx_next;
    logic                     xwide_reg, xwide_next;
    logic [1:0]               cidx_reg, cidx_next;
    logic [COEF_W-1:0]        coef_reg [3];
    logic [COEF_W-1:0]        coef_next [3];
    fit_status_t              status_reg, status_next;
    logic [COEF_W-1:0]        oc0_reg, oc0_next;
    logic [COEF_W-1:0]        oc1_reg, oc1_next;
    logic [COEF_W-1:0]        oc2_reg, oc2_next;
    fit_status_t              ostat_reg, ostat_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    solve_op_t                op;
    opnd_t                    opnd_sel;
    logic signed [OPND_W-1:0] opnd_val;
    mul_req_t                 mul_req;
    logic signed [OPND_W-1:0] mul_x;
    logic signed [SUM_W-1:0]  mul_y;
    logic                     mul_done;
    logic signed [ACC_W-1:0]  mul_acc;
    logic                     div_start;
    logic                     div_done;
    logic [COEF_W-1:0]        div_quot;
    logic signed [ACC_W-1:0]  rnd_wide;
    logic signed [SUM_W-1:0]  fx;
    logic                     cfg_wr;

    wpf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .acc   (mul_acc)
    );

    wpf_div #(
        .NUM_W (NUM_W),
        .DEN_W (ACC_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({mul_acc, {OUT_FRAC{1'b0}}}),
        .den   (det_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Product rounded to the sum format: add half an LSB, floor, saturate.
    assign rnd_wide = (mul_acc + HALF) >>> FRAC_BITS;
    always_comb
    begin
        if ((&rnd_wide[ACC_W-1:SUM_W-1]) || !(|rnd_wide[ACC_W-1:SUM_W-1]))
        begin
            fx = rnd_wide[SUM_W-1:0];
        end
        else
        begin
            fx = rnd_wide[ACC_W-1] ? SMIN : SMAX;
        end
    end

    assign op       = solve_op(step_reg);
    assign opnd_sel = (state_reg == S_SOLX) ? op.xsel : op.ysel;

    always_comb
    begin
        case (opnd_sel)
            OP_S0:   opnd_val = OPND_W'(psum_reg[0]);
            OP_S1:   opnd_val = OPND_W'(psum_reg[1]);
            OP_S2:   opnd_val = OPND_W'(psum_reg[2]);
            OP_S3:   opnd_val = OPND_W'(psum_reg[3]);
            OP_S4:   opnd_val = OPND_W'(psum_reg[4]);
            OP_M0:   opnd_val = OPND_W'(msum_reg[0]);
            OP_M1:   opnd_val = OPND_W'(msum_reg[1]);
            OP_M2:   opnd_val = OPND_W'(msum_reg[2]);
            OP_C00:  opnd_val = cof_reg[0];
            OP_C01:  opnd_val = cof_reg[1];
            OP_C02:  opnd_val = cof_reg[2];
            OP_C11:  opnd_val = cof_reg[3];
            OP_C12:  opnd_val = cof_reg[4];
            OP_C22:  opnd_val = cof_reg[5];
            default: opnd_val = '0;
        endcase
    end

    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        state_next    = state_reg;
        use_w_next    = use_w_reg;
        count_next    = count_reg;
        psum_next     = psum_reg;
        msum_next     = msum_reg;
        cof_next      = cof_reg;
        det_next      = det_reg;
        val_next      = val_reg;
        absc_next     = absc_reg;
        last_next     = last_reg;
        term_next     = term_reg;
        k_next        = k_reg;
        step_next     = step_reg;
        opx_next      = opx_reg;
        xwide_next    = xwide_reg;
        cidx_next     = cidx_reg;
        coef_next     = coef_reg;
        status_next   = status_reg;
        oc0_next      = oc0_reg;
        oc1_next      = oc1_reg;
        oc2_next      = oc2_reg;
        ostat_next    = ostat_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mul_req       = '0;
        mul_x         = OPND_W'(term_reg);
        mul_y         = SUM_W'(absc_reg);
        div_start     = 1'b0;

        if (cfg_wr && paddr == REG_USE_WEIGHTS)
        begin
            use_w_next = pwdata[0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    val_next  = s_tdata[DATA_W-1:0];
                    absc_next = s_tdata[2*DATA_W-1:DATA_W];
                    last_next = s_tlast;
                    if (count_reg < CNT_W'(MAX_POINTS))
                    begin
                        count_next = count_reg + CNT_W'(1);
                        term_next  = use_w_reg ? SUM_W'({1'b0, s_tdata[3*DATA_W-1:2*DATA_W]})
                                               : ONE;
                        k_next     = 3'd0;
                        state_next = S_PSUM;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_PSUM:
            begin
                psum_next[k_reg] = sat_add64(psum_reg[k_reg], term_reg);
                if (k_reg < 3'd3)
                begin
                    mul_req.start = 1'b1;
                    mul_req.clear = 1'b1;
                    mul_y         = SUM_W'(val_reg);
                    state_next    = S_MWAIT;
                end
                else if (k_reg < 3'd4)
                begin
                    mul_req.start = 1'b1;
                    mul_req.clear = 1'b1;
                    state_next    = S_TWAIT;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_MWAIT:
            begin
                if (mul_done)
                begin
                    msum_next[k_reg[1:0]] = sat_add64(msum_reg[k_reg[1:0]], fx);
                    mul_req.start = 1'b1;
                    mul_req.clear = 1'b1;
                    state_next    = S_TWAIT;
                end
            end
            S_TWAIT:
            begin
                if (mul_done)
                begin
                    term_next  = fx;
                    k_next     = k_reg + 3'd1;
                    state_next = S_PSUM;
                end
            end
            S_CHECK:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (count_reg < CNT_W'(MIN_POINTS))
                begin
                    status_next = FIT_FEW;
                    state_next  = S_OUT;
                end
                else
                begin
                    step_next  = '0;
                    cidx_next  = 2'd0;
                    state_next = S_SOLX;
                end
            end
            S_SOLX:
            begin
                // One read mux gives an operand per cycle between multiplies.
                opx_next   = opnd_val;
                xwide_next = (op.xsel == OP_C00) || (op.xsel == OP_C01) ||
                             (op.xsel == OP_C02) || (op.xsel == OP_C11) ||
                             (op.xsel == OP_C12) || (op.xsel == OP_C22);
                state_next = S_SOLY;
            end
            S_SOLY:
            begin
                mul_req.start  = 1'b1;
                mul_req.x_wide = xwide_reg;
                mul_req.y_wide = 1'b1;
                mul_req.clear  = op.clear;
                mul_req.sub    = op.sub;
                mul_x          = opx_reg;
                mul_y          = opnd_val[SUM_W-1:0];
                state_next     = S_SWAIT;
            end
            S_SWAIT:
            begin
                if (mul_done)
                begin
                    step_next  = step_reg + STEP_W'(1);
                    state_next = S_SOLX;
                    case (op.dest)
                        D_C00: cof_next[0] = mul_acc[OPND_W-1:0];
                        D_C01: cof_next[1] = mul_acc[OPND_W-1:0];
                        D_C02: cof_next[2] = mul_acc[OPND_W-1:0];
                        D_C11: cof_next[3] = mul_acc[OPND_W-1:0];
                        D_C12: cof_next[4] = mul_acc[OPND_W-1:0];
                        D_C22: cof_next[5] = mul_acc[OPND_W-1:0];
                        D_DET:
                        begin
                            det_next = mul_acc;
                            if (mul_acc == '0)
                            begin
                                status_next = FIT_SINGULAR;
                                state_next  = S_OUT;
                            end
                        end
                        D_NUM:
                        begin
                            div_start  = 1'b1;
                            state_next = S_DWAIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    coef_next[cidx_reg] = div_quot;
                    cidx_next = cidx_reg + 2'd1;
                    if (cidx_reg == 2'd2)
                    begin
                        status_next = FIT_OK;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SOLX;
                    end
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    ostat_next    = status_reg;
                    oc0_next      = (status_reg == FIT_OK) ? coef_reg[0] : '0;
                    oc1_next      = (status_reg == FIT_OK) ? coef_reg[1] : '0;
                    oc2_next      = (status_reg == FIT_OK) ? coef_reg[2] : '0;
                    count_next    = '0;
                    for (int i = 0; i < 5; i++)
                    begin
                        psum_next[i] = '0;
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        msum_next[i] = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            use_w_reg    <= 1'b1;
            count_reg    <= '0;
            psum_reg     <= '{default: '0};
            msum_reg     <= '{default: '0};
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            use_w_reg    <= use_w_next;
            count_reg    <= count_next;
            psum_reg     <= psum_next;
            msum_reg     <= msum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cof_reg    <= cof_next;
        det_reg    <= det_next;
        val_reg    <= val_next;
        absc_reg   <= absc_next;
        last_reg   <= last_next;
        term_reg   <= term_next;
        k_reg      <= k_next;
        step_reg   <= step_next;
        opx_reg    <= opx_next;
        xwide_reg  <= xwide_next;
        cidx_reg   <= cidx_next;
        coef_reg   <= coef_next;
        status_reg <= status_next;
        oc0_reg    <= oc0_next;
        oc1_reg    <= oc1_next;
        oc2_reg    <= oc2_next;
        ostat_reg  <= ostat_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, ostat_reg, oc2_reg, oc1_reg, oc0_reg};
    assign prdata   = (paddr == REG_USE_WEIGHTS) ? {31'b0, use_w_reg} : 32'b0;
    assign pready   = 1'b1;

    // A new result always coincides with the sums being cleared for the next set.
    a_clear_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> (count_reg == '0) && (psum_reg[0] == '0))
        else $error("sums not cleared when result issued");

    // An error status carries all-zero coefficients.
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && ostat_reg != FIT_OK) |->
            (oc0_reg == '0) && (oc1_reg == '0) && (oc2_reg == '0))
        else $error("nonzero coefficients with error status");

    // The arithmetic units are quiet whenever a new point can be taken.
    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !mul_done && !div_done)
        else $error("unit finished while block idle");

    // A division only ever completes while the sequencer waits for it.
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DWAIT)
        else $error("division completed outside its wait state");

endmodule

// ----- design/wpf_mul.sv -----
// Shared multiply-accumulate unit: a 128 x 64 bit signed product built from
// 32 x 32 bit partial products, added to or subtracted from an accumulator.
// Depends on wpf_pkg.
module wpf_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wpf_pkg::mul_req_t                   req,
    input  logic signed [wpf_pkg::OPND_W-1:0]   x,
    input  logic signed [wpf_pkg::SUM_W-1:0]    y,
    output logic                                done,
    output logic signed [wpf_pkg::ACC_W-1:0]    acc
);
    import wpf_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_ADD, M_FIN} state_t;

    state_t                    state_reg, state_next;
    logic [OPND_W-1:0]         xm_reg, xm_next;
    logic [SUM_W-1:0]          ym_reg, ym_next;
    logic [1:0]                i_reg, i_next;
    logic                      j_reg, j_next;
    logic [1:0]                ilast_reg, ilast_next;
    logic                      jlast_reg, jlast_next;
    logic                      clear_reg, clear_next;
    logic                      neg_reg, neg_next;
    logic [2*DATA_W-1:0]       pp_reg, pp_next;
    logic [2:0]                off_reg, off_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      done_reg, done_next;

    logic [DATA_W-1:0]         xlimb;
    logic [DATA_W-1:0]         ylimb;
    logic [PROD_W-1:0]         pp_shift;
    logic signed [ACC_W-1:0]   base;
    logic signed [ACC_W-1:0]   prod_ext;

    assign xlimb    = xm_reg[i_reg*DATA_W +: DATA_W];
    assign ylimb    = ym_reg[j_reg*DATA_W +: DATA_W];
    assign pp_shift = {{(PROD_W-2*DATA_W){1'b0}}, pp_reg} << {off_reg, 5'b0};
    assign base     = clear_reg ? '0 : acc_reg;
    assign prod_ext = {{(ACC_W-PROD_W){1'b0}}, prod_reg};

    always_comb
    begin
        state_next = state_reg;
        xm_next    = xm_reg;
        ym_next    = ym_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ilast_next = ilast_reg;
        jlast_next = jlast_reg;
        clear_next = clear_reg;
        neg_next   = neg_reg;
        pp_next    = pp_reg;
        off_next   = off_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    // Work on magnitudes; the sign is applied when accumulating.
                    xm_next    = x[OPND_W-1] ? OPND_W'(-x) : OPND_W'(x);
                    ym_next    = y[SUM_W-1] ? SUM_W'(-y) : SUM_W'(y);
                    neg_next   = x[OPND_W-1] ^ y[SUM_W-1] ^ req.sub;
                    clear_next = req.clear;
                    ilast_next = req.x_wide ? 2'd3 : 2'd1;
                    jlast_next = req.y_wide;
                    i_next     = 2'd0;
                    j_next     = 1'b0;
                    prod_next  = '0;
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                pp_next    = xlimb * ylimb;
                off_next   = 3'(i_reg) + 3'(j_reg);
                state_next = M_ADD;
            end
            M_ADD:
            begin
                prod_next = prod_reg + pp_shift;
                if (i_reg == ilast_reg)
                begin
                    i_next = 2'd0;
                    if (j_reg == jlast_reg)
                    begin
                        state_next = M_FIN;
                    end
                    else
                    begin
                        j_next     = 1'b1;
                        state_next = M_MUL;
                    end
                end
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = M_MUL;
                end
            end
            M_FIN:
            begin
                acc_next   = neg_reg ? base - prod_ext : base + prod_ext;
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xm_reg    <= xm_next;
        ym_reg    <= ym_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        ilast_reg <= ilast_next;
        jlast_reg <= jlast_next;
        clear_reg <= clear_next;
        neg_reg   <= neg_next;
        pp_reg    <= pp_next;
        off_reg   <= off_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

// ----- design/wpf_div.sv -----
// Bit-serial restoring divider: round(num / den) half away from zero,
// saturated to a 48-bit signed coefficient. Depends on wpf_pkg.
module wpf_div #(
    parameter int NUM_W = wpf_pkg::NUM_W,
    parameter int DEN_W = wpf_pkg::ACC_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [NUM_W-1:0]            num,
    input  logic signed [DEN_W-1:0]            den,
    output logic                               done,
    output logic [wpf_pkg::COEF_W-1:0]         quot
);
    import wpf_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int QW    = COEF_W + 1;
    localparam logic [QW:0] LIM = (QW+1)'(1) << (COEF_W - 1);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} state_t;

    state_t               state_reg, state_next;
    logic [NUM_W-1:0]     na_reg, na_next;
    logic [DEN_W-1:0]     da_reg, da_next;
    logic [DEN_W-1:0]     r_reg, r_next;
    logic [QW-1:0]        q_reg, q_next;
    logic                 ovf_reg, ovf_next;
    logic                 neg_reg, neg_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [COEF_W-1:0]    quot_reg, quot_next;
    logic                 done_reg, done_next;

    logic [DEN_W:0]       r_sh;
    logic                 ge;
    logic                 rnd;
    logic [QW:0]          qm;

    assign r_sh = {r_reg, na_reg[NUM_W-1]};
    assign ge   = r_sh >= {1'b0, da_reg};
    assign rnd  = {r_reg, 1'b0} >= {1'b0, da_reg};

    always_comb
    begin
        state_next = state_reg;
        na_next    = na_reg;
        da_next    = da_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        ovf_next   = ovf_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        quot_next  = quot_reg;
        done_next  = 1'b0;
        qm         = ovf_reg ? LIM : ({1'b0, q_reg} + (QW+1)'(rnd));
        if (qm > LIM)
        begin
            qm = LIM;
        end
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    na_next    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                    da_next    = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
                    neg_next   = num[NUM_W-1] ^ den[DEN_W-1];
                    r_next     = '0;
                    q_next     = '0;
                    ovf_next   = 1'b0;
                    cnt_next   = CNT_W'(NUM_W);
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                r_next   = ge ? DEN_W'(r_sh - {1'b0, da_reg}) : DEN_W'(r_sh);
                // Any quotient bit beyond the kept width means saturation.
                ovf_next = ovf_reg | q_reg[QW-1];
                q_next   = {q_reg[QW-2:0], ge};
                na_next  = {na_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = D_FIN;
                end
            end
            D_FIN:
            begin
                if (neg_reg)
                begin
                    quot_next = COEF_W'((QW+1)'(0) - qm);
                end
                else if (qm > LIM - (QW+1)'(1))
                begin
                    quot_next = COEF_W'(LIM - (QW+1)'(1));
                end
                else
                begin
                    quot_next = COEF_W'(qm);
                end
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        na_reg   <= na_next;
        da_reg   <= da_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
